>>> rtl/great_circle_distance_defines.svh
// ----------------------------------------------------------------------------
// Great-circle distance: assertion macros
// Wraps the concurrent checks of the block so that synthesis sees none.
// ----------------------------------------------------------------------------
`ifndef GREAT_CIRCLE_DISTANCE_DEFINES_SVH
`define GREAT_CIRCLE_DISTANCE_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define GCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define GCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GCD_ASSERT_SAME(label, ante, cons, msg)
`define GCD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/gcd_pkg.sv
// ----------------------------------------------------------------------------
// Great-circle distance: shared package
// Fixed-point constants, the arctangent table and the angle folding helper.
// ----------------------------------------------------------------------------
`default_nettype none

package gcd_pkg;

    // Reduced angle in half-microdegree units, signed.
    localparam int ANGLE_W  = 29;
    // Magnitude of a reduced angle.
    localparam int MAG_W    = 28;
    // Width of the CORDIC datapath, signed Q30 with headroom.
    localparam int CW       = 34;
    // Quotient bits of the radian conversion.
    localparam int DIV_BITS = 30;
    // Width of the conversion numerator.
    localparam int NUM_W    = 62;

    localparam logic [33:0] PI_Q32      = 34'd13493037705;
    // Four times a full turn in half-microdegree units.
    localparam logic [31:0] RAD_DEN     = 32'd2880000000;
    // Pi in Q32 over the conversion divisor, scaled by 2^32 and rounded down.
    localparam logic [65:0] RECIP_NUM   = {PI_Q32, 32'd0};
    localparam logic [34:0] RAD_RECIP   = 35'(RECIP_NUM / 66'(RAD_DEN));
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam int unsigned MAX_DISTANCE = 20015087;
    localparam int unsigned EARTH_RADIUS = 6371000;

    // Turn constants in half-microdegree units.
    localparam logic signed [30:0] FULL_TURN    = 31'sd720000000;
    localparam logic signed [30:0] HALF_TURN    = 31'sd360000000;
    localparam logic signed [30:0] QUARTER_TURN = 31'sd180000000;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] r;
        logic                      neg;
    } fold_t;

    // Arctangent of 2^-i in Q30, rounded down.
    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] res;
        case (i)
            0:       res = 34'sd843314856;
            1:       res = 34'sd497837829;
            2:       res = 34'sd263043836;
            3:       res = 34'sd133525158;
            4:       res = 34'sd67021686;
            5:       res = 34'sd33543515;
            6:       res = 34'sd16775850;
            7:       res = 34'sd8388437;
            8:       res = 34'sd4194282;
            9:       res = 34'sd2097149;
            default: res = (i <= 30) ? CW'((64'sd1 <<< (30 - i)) - 64'sd1) : '0;
        endcase
        return res;
    endfunction

    // Wraps an angle to half a turn either way, then folds it into a
    // quarter turn either way; a folded angle negates sin and cos.
    function automatic fold_t fold_angle(input logic signed [30:0] v);
        logic signed [30:0] w;
        fold_t              res;
        w       = v;
        res.neg = 1'b0;
        if (w >= HALF_TURN) begin
            w = w - FULL_TURN;
        end else if (w < -HALF_TURN) begin
            w = w + FULL_TURN;
        end
        if (w > QUARTER_TURN) begin
            w       = w - HALF_TURN;
            res.neg = 1'b1;
        end else if (w < -QUARTER_TURN) begin
            w       = w + HALF_TURN;
            res.neg = 1'b1;
        end
        res.r = w[ANGLE_W-1:0];
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gcd_sincos.sv
// ----------------------------------------------------------------------------
// Great-circle distance: sine and cosine pipeline
// Converts a folded angle to Q30 radians by reciprocal multiplication with
// one correction step, then runs a rotation CORDIC with one stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module gcd_sincos
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = 32
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [ANGLE_W-1:0] angle,
    input  logic                      fold_neg,
    output logic signed [CW-1:0]      sin_val,
    output logic signed [CW-1:0]      cos_val
);

    localparam int PP_W  = MAG_W + 17;
    localparam int EST_W = MAG_W + 18;

    logic [MAG_W-1:0] mag;
    logic [ANGLE_W-1:0] abs_angle;

    logic [PP_W-1:0]  pp_hi_reg;
    logic [PP_W-1:0]  pp_lo_reg;
    logic [EST_W-1:0] est_hi_reg;
    logic [PP_W-1:0]  est_lo_reg;
    logic             sign_a_reg;
    logic             neg_a_reg;

    logic [63:0]         est_sum;
    logic [NUM_W-1:0]    num_b_reg;
    logic [DIV_BITS-1:0] est_b_reg;
    logic                sign_b_reg;
    logic                neg_b_reg;

    logic [NUM_W-1:0]    num_c_reg;
    logic [NUM_W-1:0]    ed_c_reg;
    logic [DIV_BITS-1:0] est_c_reg;
    logic                sign_c_reg;
    logic                neg_c_reg;
    logic [NUM_W-1:0]    rem_c;

    logic [DIV_BITS-1:0] quot_reg;
    logic                sign_reg;
    logic                neg_reg;

    logic signed [CW-1:0] rx_reg [CORDIC_STEPS];
    logic signed [CW-1:0] ry_reg [CORDIC_STEPS];
    logic signed [CW-1:0] rz_reg [CORDIC_STEPS];
    logic                 rn_reg [CORDIC_STEPS];

    logic signed [CW-1:0] z_init;

    // Split the magnitude times pi, and times the scaled reciprocal, into
    // narrow partial products.
    assign abs_angle = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : angle;
    assign mag       = abs_angle[MAG_W-1:0];

    always_ff @(posedge clk) begin
        if (en) begin
            pp_hi_reg  <= PP_W'(mag) * PP_W'(PI_Q32[33:17]);
            pp_lo_reg  <= PP_W'(mag) * PP_W'(PI_Q32[16:0]);
            est_hi_reg <= EST_W'(mag) * EST_W'(RAD_RECIP[34:17]);
            est_lo_reg <= PP_W'(mag) * PP_W'(RAD_RECIP[16:0]);
            sign_a_reg <= angle[ANGLE_W-1];
            neg_a_reg  <= fold_neg;
        end
    end

    // Numerator with its rounding half, and a quotient estimate that is
    // either exact or one short.
    assign est_sum = (64'(est_hi_reg) << 17) + 64'(est_lo_reg) + (64'(1) << 31);

    always_ff @(posedge clk) begin
        if (en) begin
            num_b_reg  <= (NUM_W'(pp_hi_reg) << 17) + NUM_W'(pp_lo_reg)
                          + NUM_W'(RAD_DEN >> 1);
            est_b_reg  <= est_sum[61:32];
            sign_b_reg <= sign_a_reg;
            neg_b_reg  <= neg_a_reg;
        end
    end

    // Multiply the estimate back by the divisor.
    always_ff @(posedge clk) begin
        if (en) begin
            ed_c_reg   <= NUM_W'(est_b_reg) * NUM_W'(RAD_DEN);
            num_c_reg  <= num_b_reg;
            est_c_reg  <= est_b_reg;
            sign_c_reg <= sign_b_reg;
            neg_c_reg  <= neg_b_reg;
        end
    end

    // One compare and subtract settles the quotient.
    assign rem_c = num_c_reg - ed_c_reg;

    always_ff @(posedge clk) begin
        if (en) begin
            if (rem_c >= NUM_W'(RAD_DEN)) begin
                quot_reg <= est_c_reg + DIV_BITS'(1);
            end else begin
                quot_reg <= est_c_reg;
            end
            sign_reg <= sign_c_reg;
            neg_reg  <= neg_c_reg;
        end
    end

    // Q29 radians doubled to Q30, with the sign restored.
    always_comb begin
        z_init = {3'b000, quot_reg, 1'b0};
        if (sign_reg) begin
            z_init = -z_init;
        end
    end

    // Rotation CORDIC, one step per stage.
    for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_rot
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic                 pn;

        if (c == 0) begin : g_first
            assign px = CORDIC_GAIN;
            assign py = '0;
            assign pz = z_init;
            assign pn = neg_reg;
        end else begin : g_next
            assign px = rx_reg[c-1];
            assign py = ry_reg[c-1];
            assign pz = rz_reg[c-1];
            assign pn = rn_reg[c-1];
        end

        always_ff @(posedge clk) begin
            if (en) begin
                if (!pz[CW-1]) begin
                    rx_reg[c] <= px - (py >>> c);
                    ry_reg[c] <= py + (px >>> c);
                    rz_reg[c] <= pz - atan_q30(c);
                end else begin
                    rx_reg[c] <= px + (py >>> c);
                    ry_reg[c] <= py - (px >>> c);
                    rz_reg[c] <= pz + atan_q30(c);
                end
                rn_reg[c] <= pn;
            end
        end
    end

    // A folded angle negates both results.
    always_ff @(posedge clk) begin
        if (en) begin
            if (rn_reg[CORDIC_STEPS-1]) begin
                sin_val <= -ry_reg[CORDIC_STEPS-1];
                cos_val <= -rx_reg[CORDIC_STEPS-1];
            end else begin
                sin_val <= ry_reg[CORDIC_STEPS-1];
                cos_val <= rx_reg[CORDIC_STEPS-1];
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/great_circle_distance.sv
// ----------------------------------------------------------------------------
// Great-circle distance
// Haversine distance in metres between two points given in microdegrees.
// ----------------------------------------------------------------------------
// Usage:
// A request on the slave stream carries two points; the master stream returns
// one distance in metres for each request, in order, rounded to nearest.
// The block is a fixed pipeline with no state between requests. One request
// enters per cycle while the output is not stalled; the pipeline is built from
// the angle fold (1 stage), the radian conversion (4 stages), two CORDIC chains
// of CORDIC_STEPS stages each, the sine and cosine output (1 stage), the
// haversine products (3 stages), the square roots (32 stages) and the final
// scaling (2 stages).
// All stages advance together. When the result register holds a distance
// that the receiver does not take, the whole pipeline holds and s_tready
// drops; nothing is lost or repeated. Reset clears every valid bit, so the
// block comes out of reset empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "great_circle_distance_defines.svh"

module great_circle_distance
    import gcd_pkg::*;
#(
    parameter int CORDIC_STEPS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // from_latitude[27:0], from_longitude[56:28], to_latitude[84:57],
    // to_longitude[113:85], zero fill [119:114]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_metres[24:0], zero fill [31:25]
    output logic [31:0]  m_tdata
);

    localparam int SQRT_STEPS = 32;
    localparam int LAT_SC     = 5 + CORDIC_STEPS;
    localparam int TOTAL      = 1 + LAT_SC + 3 + SQRT_STEPS + CORDIC_STEPS + 2;
    localparam int IDX_SQRT   = LAT_SC + 3 + SQRT_STEPS;
    localparam int MW         = 36;

    // Rounded Q30 product.
    function automatic logic signed [MW-1:0] mul_q30(input logic signed [MW-1:0] p,
                                                     input logic signed [MW-1:0] q);
        logic signed [2*MW-1:0] prod;
        logic signed [2*MW-1:0] rnd;
        prod = p * q;
        rnd  = prod + ((2*MW)'(1) <<< 29);
        return rnd[MW+29:30];
    endfunction

    logic en;
    logic [TOTAL-1:0] vld_reg;

    logic signed [27:0] lat1;
    logic signed [28:0] lon1;
    logic signed [27:0] lat2;
    logic signed [28:0] lon2;
    logic signed [30:0] lat1_x;
    logic signed [30:0] lon1_x;
    logic signed [30:0] lat2_x;
    logic signed [30:0] lon2_x;
    fold_t fold_next [4];

    logic signed [ANGLE_W-1:0] fold_r_reg   [4];
    logic                      fold_neg_reg [4];
    logic signed [CW-1:0]      sin_w [4];
    logic signed [CW-1:0]      cos_w [4];

    logic signed [MW-1:0] m_dl_reg;
    logic signed [MW-1:0] m_cc_reg;
    logic signed [MW-1:0] m_do_reg;
    logic signed [MW-1:0] m_dl2_reg;
    logic signed [MW-1:0] m_t_reg;
    logic signed [MW:0]   a_sum;
    logic [30:0]          a_reg;
    logic [30:0]          b_reg;

    logic [63:0] sq_n_reg [2][SQRT_STEPS];
    logic [63:0] sq_r_reg [2][SQRT_STEPS];

    logic signed [CW-1:0] vx_reg [CORDIC_STEPS];
    logic signed [CW-1:0] vy_reg [CORDIC_STEPS];
    logic signed [CW-1:0] vz_reg [CORDIC_STEPS];

    logic [31:0] z_clamp;
    logic [54:0] prod_reg;
    logic [55:0] d_round;
    logic [24:0] dist_reg;
    logic        roots_ok;

    // The pipeline advances unless a finished result is held back.
    assign en       = !vld_reg[TOTAL-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL-1];
    assign m_tdata  = {7'b0, dist_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_tvalid};
        end
    end

    // Unpack, form differences in half-microdegree units and fold.
    assign lat1   = s_tdata[27:0];
    assign lon1   = s_tdata[56:28];
    assign lat2   = s_tdata[84:57];
    assign lon2   = s_tdata[113:85];
    assign lat1_x = 31'(lat1);
    assign lon1_x = 31'(lon1);
    assign lat2_x = 31'(lat2);
    assign lon2_x = 31'(lon2);

    always_comb begin
        fold_next[0] = fold_angle(lat2_x - lat1_x);
        fold_next[1] = fold_angle(lon2_x - lon1_x);
        fold_next[2] = fold_angle(lat1_x <<< 1);
        fold_next[3] = fold_angle(lat2_x <<< 1);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                fold_r_reg[i]   <= fold_next[i].r;
                fold_neg_reg[i] <= fold_next[i].neg;
            end
        end
    end

    // Sine of both half differences, cosine of both latitudes.
    for (genvar g = 0; g < 4; g++) begin : g_sc
        gcd_sincos #(
            .CORDIC_STEPS (CORDIC_STEPS)
        ) u_sincos (
            .clk      (clk),
            .en       (en),
            .angle    (fold_r_reg[g]),
            .fold_neg (fold_neg_reg[g]),
            .sin_val  (sin_w[g]),
            .cos_val  (cos_w[g])
        );
    end

    // Haversine term over three stages, clamped to [0, 1].
    always_comb begin
        a_sum = (MW+1)'(m_dl2_reg) + (MW+1)'(m_t_reg);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            m_dl_reg  <= mul_q30(MW'(sin_w[0]), MW'(sin_w[0]));
            m_do_reg  <= mul_q30(MW'(sin_w[1]), MW'(sin_w[1]));
            m_cc_reg  <= mul_q30(MW'(cos_w[2]), MW'(cos_w[3]));
            m_dl2_reg <= m_dl_reg;
            m_t_reg   <= mul_q30(m_cc_reg, m_do_reg);
            if (a_sum[MW]) begin
                a_reg <= '0;
                b_reg <= 31'(1) << 30;
            end else if (a_sum > (MW+1)'(1 << 30)) begin
                a_reg <= 31'(1) << 30;
                b_reg <= '0;
            end else begin
                a_reg <= a_sum[30:0];
                b_reg <= (31'(1) << 30) - a_sum[30:0];
            end
        end
    end

    // Floor square roots of a and 1 - a, one result bit per stage.
    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
        for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
            localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
            logic [63:0] pn;
            logic [63:0] pr;
            logic [63:0] tsum;

            if (k == 0) begin : g_first
                assign pn = (ln == 0) ? (64'(a_reg) << 30) : (64'(b_reg) << 30);
                assign pr = '0;
            end else begin : g_next
                assign pn = sq_n_reg[ln][k-1];
                assign pr = sq_r_reg[ln][k-1];
            end
            assign tsum = pr + BIT;

            always_ff @(posedge clk) begin
                if (en) begin
                    if (pn >= tsum) begin
                        sq_n_reg[ln][k] <= pn - tsum;
                        sq_r_reg[ln][k] <= (pr >> 1) + BIT;
                    end else begin
                        sq_n_reg[ln][k] <= pn;
                        sq_r_reg[ln][k] <= pr >> 1;
                    end
                end
            end
        end
    end

    // Vectoring CORDIC for atan2 of the two roots.
    for (genvar c = 0; c < CORDIC_STEPS; c++) begin : g_vec
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;

        if (c == 0) begin : g_first
            assign px = CW'(sq_r_reg[1][SQRT_STEPS-1][30:0]);
            assign py = CW'(sq_r_reg[0][SQRT_STEPS-1][30:0]);
            assign pz = '0;
        end else begin : g_next
            assign px = vx_reg[c-1];
            assign py = vy_reg[c-1];
            assign pz = vz_reg[c-1];
        end

        always_ff @(posedge clk) begin
            if (en) begin
                if (!py[CW-1]) begin
                    vx_reg[c] <= px + (py >>> c);
                    vy_reg[c] <= py - (px >>> c);
                    vz_reg[c] <= pz + atan_q30(c);
                end else begin
                    vx_reg[c] <= px - (py >>> c);
                    vy_reg[c] <= py + (px >>> c);
                    vz_reg[c] <= pz - atan_q30(c);
                end
            end
        end
    end

    // Scale the angle by the radius, round and saturate.
    assign z_clamp = vz_reg[CORDIC_STEPS-1][CW-1] ? '0 : vz_reg[CORDIC_STEPS-1][31:0];
    assign d_round = 56'(prod_reg) + (56'(1) << 28);

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= 55'(z_clamp) * 55'(EARTH_RADIUS);
            if (d_round[55:29] > 27'(MAX_DISTANCE)) begin
                dist_reg <= 25'(MAX_DISTANCE);
            end else begin
                dist_reg <= d_round[53:29];
            end
        end
    end

    // Both roots stay within one in Q30.
    assign roots_ok = sq_r_reg[0][SQRT_STEPS-1] <= 64'(1) << 30
                      && sq_r_reg[1][SQRT_STEPS-1] <= 64'(1) << 30;

    // Checks.
    `GCD_ASSERT_SAME(a_dist_bound, m_tvalid, m_tdata[24:0] <= 25'(MAX_DISTANCE), "distance over bound")
    `GCD_ASSERT_NEXT(a_stall_hold, !s_tready, $stable(vld_reg), "pipeline moved during stall")
    `GCD_ASSERT_NEXT(a_advance, en && vld_reg[TOTAL-2], m_tvalid, "result lost at output")
    `GCD_ASSERT_SAME(a_root_bound, vld_reg[IDX_SQRT], roots_ok, "square root out of range")

endmodule

`default_nettype wire
